### sv/slrp_pkg.sv
// Package for the sorted line run profiler: sizes, character codes, order codes,
// the stage payload type and saturating/varint helper functions. No dependencies.
`timescale 1ns / 1ps

package slrp_pkg;

    localparam int MAX_LINE_BYTES = 4096;
    localparam int COUNTER_BITS   = 48;
    localparam int FIELD_W        = 48;
    localparam int LEN_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int IDX_W          = $clog2(MAX_LINE_BYTES);
    localparam int ADDR_W         = IDX_W + 1;
    localparam int STORE_DEPTH    = 2 ** ADDR_W;
    localparam int LEB_GROUP      = 7;
    localparam int LEB_MAX        = (COUNTER_BITS + LEB_GROUP - 1) / LEB_GROUP;
    localparam int LEB_W          = $clog2(LEB_MAX + 1);
    localparam int INC_W          = LEB_W + 2;
    localparam int CTR_XW         = COUNTER_BITS + 1;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef logic [COUNTER_BITS-1:0] t_ctr;
    typedef logic [LEN_W-1:0]        t_len;
    typedef logic [INC_W-1:0]        t_inc;

    localparam t_ctr CTR_MAX = '1;

    typedef enum logic [1:0] {
        ORD_EQ           = 2'd0,
        ORD_PREV_LESS    = 2'd1,
        ORD_PREV_GREATER = 2'd2
    } t_order;

    typedef struct packed {
        logic       valid;
        logic       count;
        logic       put;
        logic       cmp_en;
        logic [7:0] data;
        logic       is_nl;
        logic       last;
        logic       line_end;
        t_len       cur_len;
        t_len       prev_len;
        logic       trunc;
    } t_s1;

    function automatic logic [LEB_W-1:0] leb_size(input t_ctr v);
        logic [LEB_W-1:0] n;
        n = LEB_W'(1);
        for (int k = 1; k < LEB_MAX; k++) begin
            if ((v >> (LEB_GROUP * k)) != '0) begin
                n = LEB_W'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic t_ctr sat_add(input t_ctr a, input t_inc b);
        logic [CTR_XW-1:0] s;
        s = {1'b0, a} + CTR_XW'(b);
        return s[COUNTER_BITS] ? CTR_MAX : s[COUNTER_BITS-1:0];
    endfunction

endpackage

### sv/slrp_in_if.sv
// Input byte channel of the sorted line run profiler: valid/ready plus one file byte.
// No dependencies.
`timescale 1ns / 1ps

interface slrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/slrp_out_if.sv
// Result channel of the sorted line run profiler: valid/ready plus per-line statistics.
// Depends on slrp_pkg.
`timescale 1ns / 1ps

interface slrp_out_if import slrp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] bytes_seen;
    logic [FIELD_W-1:0] lines_seen;
    logic [FIELD_W-1:0] newlines_seen;
    logic [FIELD_W-1:0] run_count;
    logic [FIELD_W-1:0] order_violations;
    logic [FIELD_W-1:0] run_metadata_bytes;
    logic [1:0]         line_order;
    logic               line_truncated;
    logic               ends_with_newline;
    logic               final_result;

    modport source (
        output valid, output bytes_seen, output lines_seen, output newlines_seen,
        output run_count, output order_violations, output run_metadata_bytes,
        output line_order, output line_truncated, output ends_with_newline,
        output final_result, input ready
    );
    modport sink (
        input valid, input bytes_seen, input lines_seen, input newlines_seen,
        input run_count, input order_violations, input run_metadata_bytes,
        input line_order, input line_truncated, input ends_with_newline,
        input final_result, output ready
    );
endinterface

### sv/sorted_line_run_profiler.sv
// Sorted line run profiler top level; uses slrp_pkg, slrp_in_if and slrp_out_if.
// A line's result passes the stage 1 register r_s1 and then the output register.
// Throughput: one byte per cycle unless a result waits at the output; a held CR
// ahead of a non-newline byte is written alone; the line store takes one write a cycle.
// Reset: synchronous, active low, clears control and counters; the two-bank line
// store is not cleared. After the final beat, stage 0 and the counters are reset.
`timescale 1ns / 1ps

module sorted_line_run_profiler import slrp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slrp_in_if.sink    i_byte_ch,
    slrp_out_if.source o_result_ch
);

    // stage 0 state
    logic r_bank, n_bank;
    t_len r_cur_len, n_cur_len;
    t_len r_prev_len, n_prev_len;
    logic r_held, n_held;
    logic r_trunc, n_trunc;

    // line store: bank r_bank holds the previous line, the other bank the current one
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_rd_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    t_s1 r_s1, n_s1;

    // stage 1 state
    t_order r_cmp, n_cmp;
    t_ctr r_bytes, n_bytes;
    t_ctr r_lines, n_lines;
    t_ctr r_nls, n_nls;
    t_ctr r_runs, n_runs;
    t_ctr r_viol, n_viol;
    t_ctr r_meta, n_meta;
    t_ctr r_run_start, n_run_start;
    t_ctr r_run_len, n_run_len;

    // output register
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_bytes;
    logic [FIELD_W-1:0] r_out_lines;
    logic [FIELD_W-1:0] r_out_nls;
    logic [FIELD_W-1:0] r_out_runs;
    logic [FIELD_W-1:0] r_out_viol;
    logic [FIELD_W-1:0] r_out_meta;
    t_order             r_out_order;
    logic               r_out_trunc;
    logic               r_out_ends_nl;
    logic               r_out_final;

    logic       en1;
    logic       acc;
    logic       flush;
    logic       line_end;
    logic       put;
    logic       fits;
    logic       do_put;
    logic [7:0] put_data;
    t_len       cur_after;
    logic       trunc_after;
    logic       s1_fire;

    logic   first;
    t_order order;
    logic   new_run;
    t_ctr   lines_inc;
    t_ctr   bytes_nx, nls_nx, runs_nx, viol_nx, meta_nx, start_nx, len_nx;
    t_inc   close_inc;
    t_inc   final_inc;

    // ---------------- stage 0: split, hold CR, write line store ----------------
    assign en1 = !(r_s1.valid && r_s1.line_end) || !r_out_valid || o_result_ch.ready;
    assign i_byte_ch.ready = en1 && !(r_held && i_byte_ch.data_byte != CHAR_NL);
    assign acc   = i_byte_ch.valid && i_byte_ch.ready;
    assign flush = en1 && i_byte_ch.valid && r_held && i_byte_ch.data_byte != CHAR_NL;

    always_comb begin
        line_end    = acc && (i_byte_ch.data_byte == CHAR_NL || i_byte_ch.last_byte);
        put         = flush || (acc && i_byte_ch.data_byte != CHAR_NL
                                    && i_byte_ch.data_byte != CHAR_CR);
        put_data    = flush ? CHAR_CR : i_byte_ch.data_byte;
        fits        = r_cur_len < LEN_W'(MAX_LINE_BYTES);
        do_put      = put && fits;
        cur_after   = r_cur_len + LEN_W'(do_put);
        trunc_after = r_trunc || (put && !fits);

        n_s1.valid    = acc || flush;
        n_s1.count    = acc;
        n_s1.put      = do_put;
        n_s1.cmp_en   = r_cur_len < r_prev_len;
        n_s1.data     = put_data;
        n_s1.is_nl    = acc && i_byte_ch.data_byte == CHAR_NL;
        n_s1.last     = acc && i_byte_ch.last_byte;
        n_s1.line_end = line_end;
        n_s1.cur_len  = cur_after;
        n_s1.prev_len = r_prev_len;
        n_s1.trunc    = trunc_after;
    end

    always_comb begin
        n_bank     = r_bank;
        n_prev_len = r_prev_len;
        n_cur_len  = r_cur_len;
        n_trunc    = r_trunc;
        n_held     = r_held;
        if (flush) begin
            n_cur_len = cur_after;
            n_trunc   = trunc_after;
            n_held    = 1'b0;
        end else if (acc) begin
            if (line_end) begin
                n_held    = 1'b0;
                n_trunc   = 1'b0;
                n_cur_len = '0;
                if (i_byte_ch.last_byte) begin
                    n_bank     = 1'b0;
                    n_prev_len = '0;
                end else begin
                    n_bank     = !r_bank;
                    n_prev_len = cur_after;
                end
            end else begin
                n_cur_len = cur_after;
                n_trunc   = trunc_after;
                n_held    = i_byte_ch.data_byte == CHAR_CR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank     <= 1'b0;
            r_prev_len <= '0;
            r_cur_len  <= '0;
            r_trunc    <= 1'b0;
            r_held     <= 1'b0;
        end else begin
            r_bank     <= n_bank;
            r_prev_len <= n_prev_len;
            r_cur_len  <= n_cur_len;
            r_trunc    <= n_trunc;
            r_held     <= n_held;
        end
    end

    // writes and reads hit opposite banks, so no same-entry overlap
    assign wr_addr = {!r_bank, r_cur_len[IDX_W-1:0]};
    assign rd_addr = {r_bank, r_cur_len[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (do_put) begin
            r_store[wr_addr] <= put_data;
        end
        if (en1) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en1) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 1: compare, line close, counters ----------------
    assign s1_fire = r_s1.valid && en1;

    always_comb begin
        n_cmp = r_cmp;
        if (r_s1.put && r_s1.cmp_en && r_cmp == ORD_EQ) begin
            if (r_rd_data < r_s1.data) begin
                n_cmp = ORD_PREV_LESS;
            end else if (r_rd_data > r_s1.data) begin
                n_cmp = ORD_PREV_GREATER;
            end
        end

        first = r_lines == '0;
        if (first) begin
            order = ORD_EQ;
        end else if (n_cmp != ORD_EQ) begin
            order = n_cmp;
        end else if (r_s1.prev_len < r_s1.cur_len) begin
            order = ORD_PREV_LESS;
        end else if (r_s1.prev_len > r_s1.cur_len) begin
            order = ORD_PREV_GREATER;
        end else begin
            order = ORD_EQ;
        end
        new_run = first || order != ORD_EQ;

        lines_inc = sat_add(r_lines, t_inc'(1));
        bytes_nx  = r_s1.count ? sat_add(r_bytes, t_inc'(1)) : r_bytes;
        nls_nx    = r_s1.is_nl ? sat_add(r_nls, t_inc'(1)) : r_nls;
        viol_nx   = (order == ORD_PREV_GREATER) ? sat_add(r_viol, t_inc'(1)) : r_viol;
        runs_nx   = new_run ? sat_add(r_runs, t_inc'(1)) : r_runs;

        close_inc = (new_run && r_run_len != '0)
                  ? t_inc'(leb_size(r_run_start)) + t_inc'(leb_size(r_run_len)) : '0;
        start_nx  = new_run ? lines_inc : r_run_start;
        len_nx    = new_run ? t_ctr'(1) : sat_add(r_run_len, t_inc'(1));
        final_inc = r_s1.last
                  ? t_inc'(leb_size(start_nx)) + t_inc'(leb_size(len_nx)) : '0;
        meta_nx   = sat_add(r_meta, close_inc + final_inc);
    end

    always_comb begin
        n_bytes     = r_bytes;
        n_nls       = r_nls;
        n_lines     = r_lines;
        n_viol      = r_viol;
        n_runs      = r_runs;
        n_meta      = r_meta;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        if (s1_fire) begin
            n_bytes = bytes_nx;
            n_nls   = nls_nx;
            if (r_s1.line_end) begin
                n_lines     = lines_inc;
                n_viol      = viol_nx;
                n_runs      = runs_nx;
                n_meta      = meta_nx;
                n_run_start = start_nx;
                n_run_len   = len_nx;
            end
            if (r_s1.last) begin
                n_bytes     = '0;
                n_nls       = '0;
                n_lines     = '0;
                n_viol      = '0;
                n_runs      = '0;
                n_meta      = '0;
                n_run_start = '0;
                n_run_len   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp       <= ORD_EQ;
            r_bytes     <= '0;
            r_nls       <= '0;
            r_lines     <= '0;
            r_viol      <= '0;
            r_runs      <= '0;
            r_meta      <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
        end else begin
            if (s1_fire) begin
                r_cmp <= r_s1.line_end ? ORD_EQ : n_cmp;
            end
            r_bytes     <= n_bytes;
            r_nls       <= n_nls;
            r_lines     <= n_lines;
            r_viol      <= n_viol;
            r_runs      <= n_runs;
            r_meta      <= n_meta;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.line_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.line_end) begin
            r_out_bytes   <= bytes_nx[FIELD_W-1:0];
            r_out_lines   <= lines_inc[FIELD_W-1:0];
            r_out_nls     <= nls_nx[FIELD_W-1:0];
            r_out_runs    <= runs_nx[FIELD_W-1:0];
            r_out_viol    <= viol_nx[FIELD_W-1:0];
            r_out_meta    <= meta_nx[FIELD_W-1:0];
            r_out_order   <= order;
            r_out_trunc   <= r_s1.trunc;
            r_out_ends_nl <= r_s1.last && r_s1.is_nl;
            r_out_final   <= r_s1.last;
        end
    end

    assign o_result_ch.valid              = r_out_valid;
    assign o_result_ch.bytes_seen         = r_out_bytes;
    assign o_result_ch.lines_seen         = r_out_lines;
    assign o_result_ch.newlines_seen      = r_out_nls;
    assign o_result_ch.run_count          = r_out_runs;
    assign o_result_ch.order_violations   = r_out_viol;
    assign o_result_ch.run_metadata_bytes = r_out_meta;
    assign o_result_ch.line_order         = r_out_order;
    assign o_result_ch.line_truncated     = r_out_trunc;
    assign o_result_ch.ends_with_newline  = r_out_ends_nl;
    assign o_result_ch.final_result       = r_out_final;

    // ---------------- assertions ----------------
    a_result_from_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1.valid && r_s1.line_end))
        else $error("result beat without a line end");

    a_clean_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte_ch.last_byte) |=>
            (r_cur_len == '0 && r_prev_len == '0 && !r_bank && !r_held && !r_trunc))
        else $error("stage 0 not back in reset state after final beat");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_len <= LEN_W'(MAX_LINE_BYTES))
        else $error("line length beyond line store");

    a_cmp_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1.line_end |=> r_cmp == ORD_EQ)
        else $error("compare state not cleared at line end");

    a_flush_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush |=> !r_held)
        else $error("held carriage return not released after flush");

endmodule
